// ===== rtl/core/pps_timestamp_sync_unit_macros.svh =====
// Assertion macros used by the sync unit checker.
`ifndef PPS_TIMESTAMP_SYNC_UNIT_MACROS_SVH
`define PPS_TIMESTAMP_SYNC_UNIT_MACROS_SVH

// Same-cycle implication under the block clock and reset.
`define PTS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pps sync unit: same-cycle check failed");

// Next-cycle implication under the block clock and reset.
`define PTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pps sync unit: next-cycle check failed");

`endif

// ===== rtl/core/pts_pkg.sv =====
// Types, register indexes and constants of the sync pulse timestamp unit.
package pts_pkg;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PulseW = 10;

  localparam logic [CfgIdxW-1:0] CfgIdxEnable = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxPolarity = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxRate = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxPeriodLow = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxPeriodHigh = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgIdxTimeout = 3'd5;

  localparam logic [31:0] PeriodLowReset = 32'd990000;
  localparam logic [31:0] PeriodHighReset = 32'd1010000;
  localparam logic [31:0] TimeoutReset = 32'd1100000;

  localparam logic [1:0] RatePps1 = 2'd0;
  localparam logic [1:0] RatePps10 = 2'd1;
  localparam logic [1:0] RatePps100 = 2'd2;
  localparam logic [1:0] RatePps1000 = 2'd3;

  typedef struct packed {
    logic us_tick;
    logic pulse_level;
    logic clear_us;
  } pts_in_t;

  typedef struct packed {
    logic [31:0] us_count;
    logic [31:0] utc_seconds;
    logic        unlock;
    logic        second_done;
  } pts_out_t;

  typedef struct packed {
    logic        pps_enable;
    logic        edge_polarity;
    logic [1:0]  rate_select;
    logic [31:0] period_low;
    logic [31:0] period_high;
    logic [31:0] timeout_limit;
  } pts_cfg_t;

  function automatic logic [PulseW-1:0] pulse_target(input logic [1:0] rate);
    logic [PulseW-1:0] target;
    unique case (rate)
      RatePps1:    target = 10'd1;
      RatePps10:   target = 10'd10;
      RatePps100:  target = 10'd100;
      RatePps1000: target = 10'd1000;
      default:     target = 10'd1;
    endcase
    return target;
  endfunction

endpackage

// ===== rtl/core/pts_cfg_regs.sv =====
// Configuration register file with a pulse counter clear on every valid write.
module pts_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pts_pkg::CfgDataW-1:0] cfg_wdata_i,
  output pts_pkg::pts_cfg_t            cfg_o,
  output logic                         pulse_clr_o
);

  pts_pkg::pts_cfg_t cfg_d, cfg_q;
  logic              hit;

  always_comb begin
    cfg_d = cfg_q;
    hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pts_pkg::CfgIdxEnable: begin
          cfg_d.pps_enable = cfg_wdata_i[0];
          hit = 1'b1;
        end
        pts_pkg::CfgIdxPolarity: begin
          cfg_d.edge_polarity = cfg_wdata_i[0];
          hit = 1'b1;
        end
        pts_pkg::CfgIdxRate: begin
          cfg_d.rate_select = cfg_wdata_i[1:0];
          hit = 1'b1;
        end
        pts_pkg::CfgIdxPeriodLow: begin
          cfg_d.period_low = cfg_wdata_i[31:0];
          hit = 1'b1;
        end
        pts_pkg::CfgIdxPeriodHigh: begin
          cfg_d.period_high = cfg_wdata_i[31:0];
          hit = 1'b1;
        end
        pts_pkg::CfgIdxTimeout: begin
          cfg_d.timeout_limit = cfg_wdata_i[31:0];
          hit = 1'b1;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pps_enable <= 1'b0;
      cfg_q.edge_polarity <= 1'b0;
      cfg_q.rate_select <= pts_pkg::RatePps1;
      cfg_q.period_low <= pts_pkg::PeriodLowReset;
      cfg_q.period_high <= pts_pkg::PeriodHighReset;
      cfg_q.timeout_limit <= pts_pkg::TimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
  assign pulse_clr_o = hit;

endmodule

// ===== rtl/core/pts_step.sv =====
// Counter state and the per-slot update of the microsecond, pulse and seconds counts.
module pts_step #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  pts_pkg::pts_in_t   item_i,
  input  pts_pkg::pts_cfg_t  cfg_i,
  input  logic               pulse_clr_i,
  output pts_pkg::pts_out_t  result_o
);

  localparam int unsigned CmpW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  logic [COUNT_WIDTH-1:0]      micro_d, micro_q, micro_ticked;
  logic [pts_pkg::PulseW-1:0]  pulse_d, pulse_q, pulse_inc;
  logic [31:0]                 seconds_d, seconds_q;
  logic                        unlock_d, unlock_q;
  logic                        level_q;
  logic                        edge_seen, pulse_ev, done;
  logic [CmpW-1:0]             period_ext, final_ext;
  logic                        out_of_window, timed_out;

  always_comb begin
    if (item_i.clear_us) begin
      micro_ticked = '0;
    end else if (item_i.us_tick) begin
      micro_ticked = micro_q + COUNT_WIDTH'(1);
    end else begin
      micro_ticked = micro_q;
    end

    if (cfg_i.edge_polarity) begin
      edge_seen = !level_q && item_i.pulse_level;
    end else begin
      edge_seen = level_q && !item_i.pulse_level;
    end

    pulse_ev = cfg_i.pps_enable && edge_seen;
    pulse_inc = pulse_q + pts_pkg::PulseW'(1);
    done = pulse_ev && (pulse_inc >= pts_pkg::pulse_target(cfg_i.rate_select));

    micro_d = done ? '0 : micro_ticked;
    pulse_d = pulse_ev ? (done ? '0 : pulse_inc) : pulse_q;
    seconds_d = done ? seconds_q + 32'd1 : seconds_q;

    period_ext = CmpW'(micro_ticked);
    final_ext = CmpW'(micro_d);
    out_of_window = (period_ext > CmpW'(cfg_i.period_high))
                 || (period_ext < CmpW'(cfg_i.period_low));
    timed_out = cfg_i.pps_enable && (final_ext > CmpW'(cfg_i.timeout_limit));
    unlock_d = unlock_q || (done && out_of_window) || timed_out;

    result_o.us_count = final_ext[31:0];
    result_o.utc_seconds = seconds_d;
    result_o.unlock = unlock_d;
    result_o.second_done = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      micro_q <= '0;
      pulse_q <= '0;
      seconds_q <= '0;
      unlock_q <= 1'b0;
      level_q <= 1'b0;
    end else begin
      if (pulse_clr_i) begin
        pulse_q <= '0;
      end else if (accept_i) begin
        pulse_q <= pulse_d;
      end
      if (accept_i) begin
        micro_q <= micro_d;
        seconds_q <= seconds_d;
        unlock_q <= unlock_d;
        level_q <= item_i.pulse_level;
      end
    end
  end

endmodule

// ===== rtl/core/pps_timestamp_sync_unit.sv =====
// Top level of the sync pulse disciplined timestamp unit. Every accepted request is one
// clock slot and produces exactly one result in the output register; a new request is
// taken in every cycle unless stalled, through a combinational counter update between the
// state registers and the output register, and stalls only while a held result is itself
// stalled. The microsecond counter is COUNT_WIDTH bits wide and us_count shows its low
// 32 bits. Configuration writes are registered; a valid write clears the pulse counter.
module pps_timestamp_sync_unit #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  pts_pkg::pts_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pts_pkg::pts_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [pts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pts_pkg::CfgDataW-1:0] cfg_wdata_i
);

  pts_pkg::pts_cfg_t cfg;
  pts_pkg::pts_out_t result, out_data_q;
  logic              pulse_clr;
  logic              accept;
  logic              out_valid_d, out_valid_q;

  pts_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .pulse_clr_o (pulse_clr)
  );

  pts_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .cfg_i       (cfg),
    .pulse_clr_i (pulse_clr),
    .result_o    (result)
  );

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

endmodule

// ===== rtl/core/pts_checker.sv =====
// Port-level checker for the sync pulse timestamp unit and its bind to the top level.
`include "pps_timestamp_sync_unit_macros.svh"

module pts_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pts_pkg::pts_out_t out_data_o
);

  logic held, fire, taken, done_shown, unlock_taken;

  assign held = out_valid_o && out_stall_i;
  assign fire = out_valid_o && !out_stall_i;
  assign taken = in_valid_i && !in_stall_o;
  assign done_shown = out_valid_o && out_data_o.second_done;
  assign unlock_taken = fire && out_data_o.unlock;

  `PTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, held, out_valid_o && $stable(out_data_o))
  `PTS_ASSERT_NOW(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, held)
  `PTS_ASSERT_NOW(a_second_clears_count, clk_i, rst_ni, done_shown, out_data_o.us_count == '0)
  `PTS_ASSERT_NEXT(a_unlock_sticky, clk_i, rst_ni, unlock_taken, !out_valid_o || out_data_o.unlock)
  `PTS_ASSERT_NEXT(a_request_result, clk_i, rst_ni, taken, out_valid_o)

endmodule

bind pps_timestamp_sync_unit pts_checker u_pts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sync pulse timestamp unit with a slot predictor.
module tb_top;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  pts_pkg::pts_in_t             in_data = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  pts_pkg::pts_out_t            out_data;
  logic                         cfg_we = 1'b0;
  logic [pts_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [pts_pkg::CfgDataW-1:0] cfg_wdata = '0;

  pts_pkg::pts_in_t  slot_q[$];
  pts_pkg::pts_out_t timestamp_q[$];

  int snd_idle_pct = 6;
  int rcv_idle_pct = 61;
  int err_cnt = 0;
  int checked_cnt = 0;
  int done_cnt = 0;
  int wr_cnt = 0;

  pts_pkg::pts_cfg_t cfg_shadow;
  logic [31:0]       us_ctr = '0;
  logic [9:0]        pulse_ctr = '0;
  logic [31:0]       sec_ctr = '0;
  logic              unlock_st = 1'b0;
  logic              last_lvl = 1'b0;

  bit    pin_lvl = 1'b0;
  bit    gen_pol = 1'b0;
  int    gen_us = 0;
  string cause_name;

  pps_timestamp_sync_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [9:0] pulses_needed(logic [1:0] rate);
    case (rate)
      pts_pkg::RatePps1:   return 10'd1;
      pts_pkg::RatePps10:  return 10'd10;
      pts_pkg::RatePps100: return 10'd100;
      default:             return 10'd1000;
    endcase
  endfunction

  function automatic void advance_timebase(pts_pkg::pts_in_t s);
    pts_pkg::pts_out_t res;
    logic              hit;
    logic [31:0]       captured;
    res = '0;
    if (s.clear_us) begin
      us_ctr = '0;
    end else if (s.us_tick) begin
      us_ctr = us_ctr + 32'd1;
    end
    hit = cfg_shadow.edge_polarity ? (!last_lvl && s.pulse_level) :
                                     (last_lvl && !s.pulse_level);
    last_lvl = s.pulse_level;
    if (cfg_shadow.pps_enable && hit) begin
      pulse_ctr = pulse_ctr + 10'd1;
      if (pulse_ctr >= pulses_needed(cfg_shadow.rate_select)) begin
        captured = us_ctr;
        us_ctr = '0;
        pulse_ctr = '0;
        sec_ctr = sec_ctr + 32'd1;
        if (captured > cfg_shadow.period_high || captured < cfg_shadow.period_low) begin
          unlock_st = 1'b1;
        end
        res.second_done = 1'b1;
        done_cnt++;
      end
    end
    if (cfg_shadow.pps_enable && us_ctr > cfg_shadow.timeout_limit) begin
      unlock_st = 1'b1;
    end
    res.us_count = us_ctr;
    res.utc_seconds = sec_ctr;
    res.unlock = unlock_st;
    timestamp_q.push_back(res);
  endfunction

  function automatic void flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("tb: %s", msg);
    end
  endfunction

  function automatic void check_result(pts_pkg::pts_out_t got);
    pts_pkg::pts_out_t want;
    checked_cnt++;
    if (timestamp_q.size() == 0) begin
      flag_error($sformatf("unexpected result us=%0d sec=%0d unlock=%0b done=%0b",
                           got.us_count, got.utc_seconds, got.unlock, got.second_done));
      return;
    end
    want = timestamp_q.pop_front();
    if (got.us_count !== want.us_count || got.utc_seconds !== want.utc_seconds ||
        got.unlock !== want.unlock || got.second_done !== want.second_done) begin
      flag_error($sformatf({"result %0d: exp us=%0d sec=%0d unlock=%0b done=%0b,",
                            " got us=%0d sec=%0d unlock=%0b done=%0b"},
                           checked_cnt, want.us_count, want.utc_seconds, want.unlock,
                           want.second_done, got.us_count, got.utc_seconds, got.unlock,
                           got.second_done));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_timebase(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (slot_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= slot_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
      end
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  function automatic logic [31:0] pad_bits(logic [31:0] v, int w);
    return ($urandom << w) | v;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 60);
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_slot(bit tick, bit lvl, bit clr);
    pts_pkg::pts_in_t s;
    s.us_tick = tick;
    s.pulse_level = lvl;
    s.clear_us = clr;
    slot_q.push_back(s);
    pin_lvl = lvl;
    if (clr) begin
      gen_us = 0;
    end else if (tick) begin
      gen_us++;
    end
  endfunction

  // One well-formed second: the capture on its last edge sees exactly the given period.
  function automatic void queue_second(int edges, int period, int tick_pct, int clr_pct,
                                       int max_gap);
    bit pre_lvl;
    bit clr;
    int gap;
    int hold;
    pre_lvl = !gen_pol;
    for (int e = 0; e < edges; e++) begin
      gap = $urandom_range(1, max_gap);
      hold = $urandom_range(0, gap - 1);
      for (int k = 0; k < gap; k++) begin
        clr = ($urandom_range(99) < clr_pct);
        push_slot(clr ? $urandom_range(1) : (gen_us < period && $urandom_range(99) < tick_pct),
                  k < hold ? pin_lvl : pre_lvl, clr);
      end
      if (e == edges - 1) begin
        while (gen_us < period - 1) push_slot(1'b1, pre_lvl, 1'b0);
      end
      push_slot(gen_us < period && (e == edges - 1 || $urandom_range(99) < tick_pct),
                gen_pol, 1'b0);
    end
    gen_us = 0;
  endfunction

  task automatic settle();
    while (slot_q.size() != 0 || in_valid || timestamp_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [pts_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    wr_cnt++;
    case (idx)
      pts_pkg::CfgIdxEnable:     cfg_shadow.pps_enable = val[0];
      pts_pkg::CfgIdxPolarity:   cfg_shadow.edge_polarity = val[0];
      pts_pkg::CfgIdxRate:       cfg_shadow.rate_select = val[1:0];
      pts_pkg::CfgIdxPeriodLow:  cfg_shadow.period_low = val;
      pts_pkg::CfgIdxPeriodHigh: cfg_shadow.period_high = val;
      pts_pkg::CfgIdxTimeout:    cfg_shadow.timeout_limit = val;
      default: ;
    endcase
    if (idx <= pts_pkg::CfgIdxTimeout) begin
      pulse_ctr = '0;
    end
  endtask

  task automatic lock_phase(bit pol, logic [1:0] rate, logic [31:0] lo, logic [31:0] hi,
                            logic [31:0] tmo, int seconds, int pmin, int pmax,
                            int tick_pct, int clr_pct, int max_gap);
    int edges;
    settle();
    write_reg(pts_pkg::CfgIdxEnable, pad_bits(32'd1, 1));
    write_reg(pts_pkg::CfgIdxPolarity, pad_bits(32'(pol), 1));
    write_reg(pts_pkg::CfgIdxRate, pad_bits(32'(rate), 2));
    write_reg(pts_pkg::CfgIdxPeriodLow, lo);
    write_reg(pts_pkg::CfgIdxPeriodHigh, hi);
    write_reg(pts_pkg::CfgIdxTimeout, tmo);
    edges = pulses_needed(rate);
    @(negedge clk_i);
    gen_pol = pol;
    push_slot($urandom_range(1), pin_lvl, 1'b1);
    repeat (seconds) queue_second(edges, $urandom_range(pmin, pmax), tick_pct, clr_pct, max_gap);
  endtask

  task automatic random_lock_phase();
    logic [1:0]  rate;
    logic [31:0] lo;
    logic [31:0] hi;
    rate = $urandom_range(1) ? pts_pkg::RatePps10 : pts_pkg::RatePps1;
    lo = $urandom_range(0, 20);
    hi = lo + $urandom_range(0, 15);
    lock_phase($urandom_range(1), rate, lo, hi, hi + $urandom_range(0, 10),
               rate == pts_pkg::RatePps1 ? 5 : 1, lo, hi, 70, 3, 3);
  endtask

  task automatic noise_phase(int n, int en_pct);
    logic [pts_pkg::CfgIdxW-1:0] idx;
    settle();
    write_reg(pts_pkg::CfgIdxEnable, pad_bits(32'($urandom_range(99) < en_pct), 1));
    repeat ($urandom_range(1, 4)) begin
      idx = $urandom_range(0, 7);
      write_reg(idx, pick_value());
    end
    @(negedge clk_i);
    repeat (n) push_slot($urandom_range(1), $urandom_range(1), $urandom_range(99) < 5);
  endtask

  initial begin
    int tmo_v;
    cfg_shadow.pps_enable = 1'b0;
    cfg_shadow.edge_polarity = 1'b0;
    cfg_shadow.rate_select = pts_pkg::RatePps1;
    cfg_shadow.period_low = pts_pkg::PeriodLowReset;
    cfg_shadow.period_high = pts_pkg::PeriodHighReset;
    cfg_shadow.timeout_limit = pts_pkg::TimeoutReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int c = 0; c < 8; c++) begin
      push_slot(c[2], c[1], c[0]);
    end
    lock_phase(1'b1, pts_pkg::RatePps1, 32'd3, 32'd5, 32'd5, 1, 3, 3, 70, 0, 2);
    lock_phase(1'b0, pts_pkg::RatePps1, 32'd3, 32'd5, 32'd5, 1, 5, 5, 70, 0, 2);

    repeat (4) random_lock_phase();
    lock_phase(1'b1, pts_pkg::RatePps1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 0, 0, 70, 0, 2);
    lock_phase(1'b0, pts_pkg::RatePps1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5, 0, 20, 70, 3, 3);
    noise_phase(100, 0);

    settle();
    snd_idle_pct = 61;
    rcv_idle_pct = 6;
    // Toggle the pin at the highest rate so the pulse count passes 10 and 100
    // without completing a second.
    lock_phase($urandom_range(1), pts_pkg::RatePps1000, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               0, 0, 0, 50, 0, 1);
    repeat (480) push_slot($urandom_range(1), !pin_lvl, 1'b0);
    lock_phase($urandom_range(1), pts_pkg::RatePps100, 32'd100, 32'd250, 32'd250, 1, 100, 250,
               80, 1, 2);

    settle();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    repeat (2) random_lock_phase();
    case ($urandom_range(2))
      0: begin
        cause_name = "short period";
        lock_phase($urandom_range(1), pts_pkg::RatePps1, 32'd10, 32'd20, 32'd30, 3, 0, 9,
                   70, 0, 3);
      end
      1: begin
        cause_name = "long period";
        lock_phase($urandom_range(1), pts_pkg::RatePps1, 32'd0, 32'd10, 32'hFFFF_FFFF, 3,
                   11, 25, 70, 0, 3);
      end
      default: begin
        cause_name = "timeout";
        tmo_v = $urandom_range(0, 10);
        lock_phase($urandom_range(1), pts_pkg::RatePps1, 32'd0, 32'hFFFF_FFFF, 32'(tmo_v), 3,
                   tmo_v + 1, tmo_v + 15, 70, 0, 3);
      end
    endcase
    repeat (5) noise_phase(60, 75);

    settle();
    repeat (3) @(posedge clk_i);
    $display("tb: %0d slot results checked, %0d seconds completed, %0d register writes",
             checked_cnt, done_cnt, wr_cnt);
    $display("tb: lock loss provoked through the %s check, then random pin noise", cause_name);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches in total", err_cnt);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: run did not complete in time");
    $display("tb: failure");
    $finish;
  end

endmodule
